// ===== hw/rtl/rba_pkg.sv =====
// Shared types, constants and word-level helper functions for the
// reference-counted block allocator. No dependencies.
`timescale 1ns / 1ps

package rba_pkg;

  // Pool geometry.
  localparam int POOL_BLOCKS = 1024;
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 16;
  localparam int ACT_W       = 11;
  localparam int STAT_W      = 2;
  localparam int OP_W        = 3;

  // Free bitmap: 32-bit words.
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = POOL_BLOCKS / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int WCNT_W    = ACT_W - BIT_W + 1;

  // Count store: four counts per row.
  localparam int ROW_SLOTS = 4;
  localparam int SLOT_W    = $clog2(ROW_SLOTS);
  localparam int ROW_W     = ROW_SLOTS * CNT_W;
  localparam int NUM_ROWS  = POOL_BLOCKS / ROW_SLOTS;
  localparam int RADDR_W   = $clog2(NUM_ROWS);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADDREF    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEREF     = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET_ALL = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_RCNT_RD,
    S_RCNT
  } seq_state_t;

  // Request bundle toward the free bitmap.
  typedef struct packed {
    logic               rd;
    logic [WADDR_W-1:0] raddr;
    logic               wr;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic               clr;
  } bm_req_t;

  // Request bundle toward the count store.
  typedef struct packed {
    logic               rd;
    logic [RADDR_W-1:0] raddr;
    logic               wr;
    logic [RADDR_W-1:0] waddr;
    logic [ROW_W-1:0]   wdata;
    logic               clr;
  } cnt_req_t;

  // Bits of bitmap word 'word' that lie below the active size n.
  function automatic logic [WORD_W-1:0] word_mask(logic [WCNT_W-1:0] word,
                                                  logic [ACT_W-1:0] n);
    logic [WCNT_W+BIT_W-1:0] rem;
    rem = {{(WCNT_W+BIT_W-ACT_W){1'b0}}, n} - {word, {BIT_W{1'b0}}};
    if (rem >= (WCNT_W+BIT_W)'(WORD_W)) begin
      return '1;
    end
    return ~({WORD_W{1'b1}} << rem[BIT_W-1:0]);
  endfunction

  // Index of the lowest set bit of a word.
  function automatic logic [BIT_W-1:0] lowest_bit(logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Number of set bits in a word.
  function automatic logic [BIT_W:0] popcnt(logic [WORD_W-1:0] w);
    logic [BIT_W:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + (BIT_W+1)'(w[i]);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rba_bitmap.sv =====
// Free bitmap: 32 words of 32 free flags, one read and one write port,
// registered read. Word valid bits make an unwritten word read as all free.
// Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_bitmap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rba_pkg::bm_req_t              req,
  output logic [rba_pkg::WORD_W-1:0]    rdata
);
  import rba_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  logic [WORD_W-1:0]    rdata_r;
  logic                 rvalid_r;

  // Storage array, written and read in place.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.raddr];
    end
  end

  // Word valid bits; a clear marks every word as all free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr) begin
        valid_r[req.waddr] <= 1'b1;
      end
      if (req.rd) begin
        rvalid_r <= valid_r[req.raddr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '1;

endmodule

// ===== hw/rtl/rba_counts.sv =====
// Reference count store: 256 rows of four 16-bit counts, one read and one
// write port, registered read. Row valid bits make an unwritten row read as
// zero. Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_counts (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rba_pkg::cnt_req_t             req,
  output logic [rba_pkg::ROW_W-1:0]     rdata
);
  import rba_pkg::*;

  logic [ROW_W-1:0]    mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] valid_r;
  logic [ROW_W-1:0]    rdata_r;
  logic                rvalid_r;

  // Storage array.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.raddr];
    end
  end

  // Row valid bits; a clear zeroes every count at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr) begin
        valid_r[req.waddr] <= 1'b1;
      end
      if (req.rd) begin
        rvalid_r <= valid_r[req.raddr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

// ===== hw/rtl/rba_seq.sv =====
// Sequencer of the block allocator: command decode, bitmap word scan and
// recount unit, count update, free total and result register.
// Depends on rba_pkg; drives rba_bitmap and rba_counts.
`timescale 1ns / 1ps

module rba_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rba_pkg::OP_W-1:0]      in_opcode,
  input  logic [rba_pkg::BLK_W-1:0]     in_block_id,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rba_pkg::ACT_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [rba_pkg::STAT_W-1:0]    out_status,
  output logic [rba_pkg::BLK_W-1:0]     out_result_block,
  output logic [rba_pkg::CNT_W-1:0]     out_count_after,
  output logic [rba_pkg::ACT_W-1:0]     out_free_total,
  output logic [rba_pkg::ACT_W-1:0]     out_used_total,
  output rba_pkg::bm_req_t              bm_req,
  input  logic [rba_pkg::WORD_W-1:0]    bm_rdata,
  output rba_pkg::cnt_req_t             cnt_req,
  input  logic [rba_pkg::ROW_W-1:0]     cnt_rdata
);
  import rba_pkg::*;

  seq_state_t          state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [BLK_W-1:0]    id_r, id_nxt;
  logic [WCNT_W-1:0]   word_r, word_nxt;
  logic [ACT_W-1:0]    acc_r, acc_nxt;
  logic [ACT_W-1:0]    free_r, free_nxt;
  logic [ACT_W-1:0]    active_r, active_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [BLK_W-1:0]    out_block_r, out_block_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic [ACT_W-1:0]    out_free_r, out_free_nxt;
  logic [ACT_W-1:0]    out_used_r, out_used_nxt;

  logic [ACT_W-1:0]    n_act;
  logic [ACT_W:0]      n_round;
  logic [WCNT_W-1:0]   n_words;
  logic [WCNT_W-1:0]   last_word;
  logic [WORD_W-1:0]   masked;
  logic [BIT_W-1:0]    low_idx;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic                was_free;
  logic [ROW_W-1:0]    row_wr;
  logic                in_range;

  // Active size capped at the pool size, and the number of bitmap words it spans.
  always_comb begin
    n_act     = (active_r > ACT_W'(POOL_BLOCKS)) ? ACT_W'(POOL_BLOCKS) : active_r;
    n_round   = {1'b0, n_act} + (ACT_W+1)'(WORD_W - 1);
    n_words   = n_round[ACT_W:BIT_W];
    last_word = n_words - WCNT_W'(1);
  end

  // Shared word unit: mask to the active range, find lowest free bit.
  assign masked  = bm_rdata & word_mask(word_r, n_act);
  assign low_idx = lowest_bit(masked);

  // Count slot of the block being updated.
  assign slot     = id_r[SLOT_W-1:0];
  assign cur_cnt  = cnt_rdata[slot*CNT_W +: CNT_W];
  assign was_free = bm_rdata[id_r[BIT_W-1:0]];
  assign in_range = {1'b0, in_block_id} < n_act;

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= ACT_W'(POOL_BLOCKS);
      active_r    <= ACT_W'(POOL_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    word_r       <= word_nxt;
    acc_r        <= acc_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_count_r  <= out_count_nxt;
    out_free_r   <= out_free_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Next state, memory requests and result loading.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    word_nxt       = word_r;
    acc_nxt        = acc_r;
    free_nxt       = free_r;
    active_nxt     = active_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_count_nxt  = out_count_r;
    out_free_nxt   = out_free_r;
    out_used_nxt   = out_used_r;
    new_cnt        = '0;
    row_wr         = cnt_rdata;
    bm_req         = '0;
    cnt_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        priority if (start) begin
          op_nxt         = in_opcode;
          id_nxt         = in_block_id;
          out_status_nxt = ST_OK;
          out_block_nxt  = '0;
          out_count_nxt  = '0;
          out_free_nxt   = free_r;
          out_used_nxt   = n_act - free_r;
          unique case (in_opcode)
            OP_ALLOC: begin
              if (n_words == '0) begin
                out_status_nxt = ST_NO_FREE;
                out_valid_nxt  = 1'b1;
              end else begin
                bm_req.rd    = 1'b1;
                bm_req.raddr = '0;
                word_nxt     = '0;
                state_nxt    = S_SCAN;
              end
            end
            OP_RELEASE, OP_ADDREF, OP_DEREF: begin
              if (in_range) begin
                bm_req.rd     = 1'b1;
                bm_req.raddr  = in_block_id[BLK_W-1:BIT_W];
                cnt_req.rd    = 1'b1;
                cnt_req.raddr = in_block_id[BLK_W-1:SLOT_W];
                state_nxt     = S_UPD;
              end else begin
                out_status_nxt = ST_RANGE;
                out_block_nxt  = in_block_id;
                out_valid_nxt  = 1'b1;
              end
            end
            OP_RESET_ALL: begin
              bm_req.clr    = 1'b1;
              cnt_req.clr   = 1'b1;
              free_nxt      = n_act;
              out_free_nxt  = n_act;
              out_used_nxt  = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              // Undefined opcodes leave the pool untouched.
              out_valid_nxt = 1'b1;
            end
          endcase
        end else if (cfg_valid) begin
          active_nxt = cfg_data;
          state_nxt  = S_RCNT_RD;
        end
      end

      // One bitmap word per cycle; the next word is read ahead.
      S_SCAN: begin
        if (masked != '0) begin
          id_nxt        = {word_r[WADDR_W-1:0], low_idx};
          bm_req.rd     = 1'b1;
          bm_req.raddr  = word_r[WADDR_W-1:0];
          cnt_req.rd    = 1'b1;
          cnt_req.raddr = id_nxt[BLK_W-1:SLOT_W];
          state_nxt     = S_UPD;
        end else if (word_r == last_word) begin
          out_status_nxt = ST_NO_FREE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          word_nxt     = word_r + WCNT_W'(1);
          bm_req.rd    = 1'b1;
          bm_req.raddr = word_nxt[WADDR_W-1:0];
        end
      end

      // Read-modify-write of the count row and the bitmap word.
      S_UPD: begin
        bm_req.waddr = id_r[BLK_W-1:BIT_W];
        bm_req.wdata = bm_rdata;
        unique case (op_r)
          OP_ALLOC: begin
            new_cnt   = CNT_W'(1);
            bm_req.wr = 1'b1;
            bm_req.wdata[id_r[BIT_W-1:0]] = 1'b0;
            free_nxt  = free_r - ACT_W'(1);
          end
          OP_ADDREF: begin
            new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
          end
          default: begin
            // Release and dereference: a count of one or less frees the block.
            if (cur_cnt <= CNT_W'(1)) begin
              new_cnt   = '0;
              bm_req.wr = 1'b1;
              bm_req.wdata[id_r[BIT_W-1:0]] = 1'b1;
              if (!was_free) begin
                free_nxt = free_r + ACT_W'(1);
              end
            end else begin
              new_cnt = cur_cnt - CNT_W'(1);
            end
          end
        endcase
        row_wr[slot*CNT_W +: CNT_W] = new_cnt;
        cnt_req.wr     = 1'b1;
        cnt_req.waddr  = id_r[BLK_W-1:SLOT_W];
        cnt_req.wdata  = row_wr;
        out_block_nxt  = id_r;
        out_count_nxt  = new_cnt;
        out_free_nxt   = free_nxt;
        out_used_nxt   = n_act - free_nxt;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      // Recount of free blocks after the active size changes.
      S_RCNT_RD: begin
        if (n_words == '0) begin
          free_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          bm_req.rd    = 1'b1;
          bm_req.raddr = '0;
          word_nxt     = '0;
          acc_nxt      = '0;
          state_nxt    = S_RCNT;
        end
      end

      S_RCNT: begin
        acc_nxt = acc_r + ACT_W'(popcnt(masked));
        if (word_r == last_word) begin
          free_nxt  = acc_nxt;
          state_nxt = S_IDLE;
        end else begin
          word_nxt     = word_r + WCNT_W'(1);
          bm_req.rd    = 1'b1;
          bm_req.raddr = word_nxt[WADDR_W-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = (state_r == S_IDLE) && !start;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_block = out_block_r;
  assign out_count_after  = out_count_r;
  assign out_free_total   = out_free_r;
  assign out_used_total   = out_used_r;

endmodule

// ===== hw/rtl/refcounted_block_allocator.sv =====
// Top level of the reference-counted block allocator: sequencer, free bitmap
// and count store. Depends on rba_pkg, rba_seq, rba_bitmap and rba_counts.
//
//   Channel  Ports                                      Handshake
//   input    in_opcode, in_block_id                     start high, busy low
//   result   out_status, out_result_block,              out_valid, one cycle
//            out_count_after, out_free_total,
//            out_used_total
//   config   cfg_data                                   cfg_valid and cfg_ready
//
// Allocate scans one 32-bit bitmap word per cycle until it finds the first
// word with a free block in the active range, then updates that block in
// S_UPD and loads the result register. Release, reference and dereference go
// straight to S_UPD. Reset all, out-of-range numbers and undefined opcodes:
// not busy, result on the next cycle. A config write recounts free blocks,
// one word per cycle. Reset needs no clearing pass.
// The result strobe cannot be held off by the receiver.
`timescale 1ns / 1ps

module refcounted_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rba_pkg::OP_W-1:0]      in_opcode,
  input  logic [rba_pkg::BLK_W-1:0]     in_block_id,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rba_pkg::ACT_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [rba_pkg::STAT_W-1:0]    out_status,
  output logic [rba_pkg::BLK_W-1:0]     out_result_block,
  output logic [rba_pkg::CNT_W-1:0]     out_count_after,
  output logic [rba_pkg::ACT_W-1:0]     out_free_total,
  output logic [rba_pkg::ACT_W-1:0]     out_used_total
);
  import rba_pkg::*;

  bm_req_t           bm_req;
  cnt_req_t          cnt_req;
  logic [WORD_W-1:0] bm_rdata;
  logic [ROW_W-1:0]  cnt_rdata;

  // Control sequencer and shared word unit.
  rba_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_block_id      (in_block_id),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_count_after  (out_count_after),
    .out_free_total   (out_free_total),
    .out_used_total   (out_used_total),
    .bm_req           (bm_req),
    .bm_rdata         (bm_rdata),
    .cnt_req          (cnt_req),
    .cnt_rdata        (cnt_rdata)
  );

  // Free flags.
  rba_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bm_req),
    .rdata (bm_rdata)
  );

  // Reference counts.
  rba_counts u_counts (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cnt_req),
    .rdata (cnt_rdata)
  );

endmodule

// ===== hw/rtl/rba_checker.sv =====
// Port-level checks for the block allocator, bound to the top level.
// Depends on rba_pkg and refcounted_block_allocator.
`timescale 1ns / 1ps

module rba_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rba_pkg::OP_W-1:0]      in_opcode,
  input  logic [rba_pkg::BLK_W-1:0]     in_block_id,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rba_pkg::ACT_W-1:0]     cfg_data,
  input  logic                          out_valid,
  input  logic [rba_pkg::STAT_W-1:0]    out_status,
  input  logic [rba_pkg::BLK_W-1:0]     out_result_block,
  input  logic [rba_pkg::CNT_W-1:0]     out_count_after,
  input  logic [rba_pkg::ACT_W-1:0]     out_free_total,
  input  logic [rba_pkg::ACT_W-1:0]     out_used_total
);
  import rba_pkg::*;

  logic [ACT_W:0] total;
  assign total = {1'b0, out_free_total} + {1'b0, out_used_total};

  // Free plus used never exceeds the pool size.
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> total <= (ACT_W+1)'(POOL_BLOCKS))
    else $error("free and used totals exceed the pool size");

  // Reset all answers on the next cycle with an empty pool.
  a_reset_all: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_RESET_ALL) |=>
      (out_valid && out_status == ST_OK && out_count_after == '0 &&
       out_used_total == '0))
    else $error("reset all did not report an empty pool");

  // Allocation failure only when nothing is free.
  a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_FREE) |->
      (out_free_total == '0 && out_count_after == '0))
    else $error("no free block reported while blocks are free");

  // Status codes stay within the defined set; range errors carry no count.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_OK || out_status == ST_NO_FREE ||
                    out_status == ST_RANGE) &&
                   (out_status != ST_RANGE || out_count_after == '0)))
    else $error("bad status or count on a range error");

  // Config writes are refused while an item is in progress.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready)
    else $error("config port ready while busy");

endmodule

bind refcounted_block_allocator rba_checker u_rba_checker (.*);
